### rtl/tde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tde_pkg
// Shared types and constants for the time-delay embedder: configuration
// register indexes, field widths, reset values, the sequencer states and the column request record.
// ----------------------------------------------------------------------------
package tde_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_EMBED_DIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_STYLE = 2'd2;

  // Register widths and reset values
  localparam int unsigned EMBED_DIM_W = 5;
  localparam int unsigned LAG_STEP_W  = 8;

  localparam logic [EMBED_DIM_W-1:0] EMBED_DIM_RST = 5'd3;
  localparam logic [LAG_STEP_W-1:0]  LAG_STEP_RST  = 8'd1;
  localparam logic                   LAG_STYLE_RST = 1'b0;

  // Result column field
  localparam int unsigned COLUMN_W = 4;

  // Column sequencer states
  typedef enum logic {
    COL_IDLE,
    COL_RUN
  } col_state_e;

  // Per-column metadata travelling from the sequencer to the output stages
  typedef struct packed {
    logic                ok;
    logic                last;
    logic [COLUMN_W-1:0] column;
  } col_req_t;

endpackage
`default_nettype wire

### rtl/tde_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tde_ram
// Generic single-write, single-read RAM with a registered read port. Read
// data holds its value while no read is requested.
// ----------------------------------------------------------------------------
module tde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/tde_col_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tde_col_gen
// Column sequencer. Walks the columns of one row, stepping the lag with one
// shared adder, checks it against the series length and forms the ring
// buffer read address for each column.
// ----------------------------------------------------------------------------
module tde_col_gen #(
  parameter int unsigned MAX_DIM       = 16,
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic [tde_pkg::EMBED_DIM_W-1:0]          embed_dim_i,
  input  wire logic [tde_pkg::LAG_STEP_W-1:0]           lag_step_i,
  input  wire logic                                     lag_style_i,
  input  wire logic                                     start_i,
  input  wire logic                                     issue_i,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0]         cur_i,
  input  wire logic [$clog2(HISTORY_DEPTH+1)-1:0]       seen_i,
  output logic                                          busy_o,
  output logic                                          req_valid_o,
  output tde_pkg::col_req_t                             req_o,
  output logic      [$clog2(HISTORY_DEPTH)-1:0]         raddr_o
);

  import tde_pkg::*;

  localparam int unsigned AW      = $clog2(HISTORY_DEPTH);
  localparam int unsigned SEEN_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CNT_W   = ($clog2(MAX_DIM) > 0) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW      = ($clog2(MAX_DIM + 1) > EMBED_DIM_W) ?
                                    $clog2(MAX_DIM + 1) : EMBED_DIM_W;
  localparam int unsigned LAG_W   = $clog2(MAX_DIM + 1) + LAG_STEP_W;
  localparam int unsigned CMP_W   = (LAG_W > SEEN_W) ? LAG_W : SEEN_W;
  localparam logic [DW-1:0] MAX_DIM_C = DW'(MAX_DIM);
  localparam logic [AW:0]   DEPTH_C   = (AW + 1)'(HISTORY_DEPTH);

  col_state_e        state_q, state_d;
  logic [CNT_W-1:0]  col_q, col_d;
  logic [LAG_W-1:0]  lag_q, lag_d;
  logic [LAG_W-1:0]  lag_init, stride;
  logic [DW-1:0]     dim_raw, dim_eff;
  logic              last;
  logic [AW:0]       diff;

  // Effective dimension: zero counts as one, large values saturate
  always_comb begin
    dim_raw = DW'(embed_dim_i);
    if (dim_raw == '0) begin
      dim_eff = DW'(1);
    end else if (dim_raw > MAX_DIM_C) begin
      dim_eff = MAX_DIM_C;
    end else begin
      dim_eff = dim_raw;
    end
  end

  // Lag of column 0 and spacing between columns
  assign stride   = (lag_step_i == '0) ? LAG_W'(1) : LAG_W'(lag_step_i);
  assign lag_init = ((lag_step_i != '0) && lag_style_i) ? LAG_W'(lag_step_i) : '0;

  assign last = (DW'(col_q) == (dim_eff - DW'(1)));

  // Ring buffer address: current slot minus lag, wrapped once
  assign diff    = {1'b0, cur_i} - {1'b0, AW'(lag_q)};
  assign raddr_o = diff[AW] ? AW'(diff + DEPTH_C) : diff[AW-1:0];

  assign req_o.ok     = (CMP_W'(lag_q) < CMP_W'(seen_i));
  assign req_o.last   = last;
  assign req_o.column = COLUMN_W'(col_q);

  // State and column registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COL_IDLE;
      col_q   <= '0;
      lag_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      lag_q   <= lag_d;
    end
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    lag_d       = lag_q;
    busy_o      = 1'b0;
    req_valid_o = 1'b0;
    unique case (state_q)
      COL_IDLE: begin
        if (start_i) begin
          state_d = COL_RUN;
          col_d   = '0;
          lag_d   = lag_init;
        end
      end
      COL_RUN: begin
        busy_o      = 1'b1;
        req_valid_o = 1'b1;
        if (issue_i) begin
          col_d = col_q + CNT_W'(1);
          lag_d = lag_q + stride;
          if (last) begin
            state_d = COL_IDLE;
          end
        end
      end
      default: begin
        state_d = COL_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/time_delay_embedder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_delay_embedder
// Streaming time-delay embedding over a ring buffer of recent samples.
// ----------------------------------------------------------------------------
// Each accepted sample is written into the history RAM at once and then
// produces one row of E results, E being embed_dim clamped to 1..MAX_DIM.
// The column sequencer issues one history read per cycle while the
// read-data stage is free or being emptied; each item is accepted, then
// read column by column through the single RAM read port. The input is
// stalled while a row is being read; results already read wait in a
// two-entry output path (read-data stage plus output register). Results
// whose lag reaches before the start of the series carry valid_res = 0
// and a zero value. The history RAM needs no initialization after reset.
// ----------------------------------------------------------------------------
module time_delay_embedder #(
  parameter int unsigned MAX_DIM       = 16,
  parameter int unsigned HISTORY_DEPTH = 4096,
  parameter int unsigned SAMPLE_BITS   = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [tde_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tde_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]           sample_i,
  input  wire logic                             series_start_i,
  // Output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [SAMPLE_BITS-1:0]           lagged_value_o,
  output logic                                  valid_res_o,
  output logic      [tde_pkg::COLUMN_W-1:0]     column_o,
  output logic                                  last_o
);

  import tde_pkg::*;

  localparam int unsigned AW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned SEEN_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0]     LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [SEEN_W-1:0] DEPTH_S   = SEEN_W'(HISTORY_DEPTH);

  logic [EMBED_DIM_W-1:0] embed_dim_q;
  logic [LAG_STEP_W-1:0]  lag_step_q;
  logic                   lag_style_q;

  logic [AW-1:0]          wp_q, wp_d;
  logic [AW-1:0]          cur_q;
  logic [SEEN_W-1:0]      seen_q, seen_d, seen_base;

  logic                   in_take;
  logic                   busy;
  logic                   req_valid;
  col_req_t               req;
  logic [AW-1:0]          raddr;
  logic                   issue;
  logic [SAMPLE_BITS-1:0] rdata;

  logic                   pend_q;
  col_req_t               pend_meta_q;
  logic                   pend_move;
  logic                   out_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      embed_dim_q <= EMBED_DIM_RST;
      lag_step_q  <= LAG_STEP_RST;
      lag_style_q <= LAG_STYLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EMBED_DIM: embed_dim_q <= cfg_wdata_i[EMBED_DIM_W-1:0];
        CFG_LAG_STEP:  lag_step_q  <= cfg_wdata_i[LAG_STEP_W-1:0];
        CFG_LAG_STYLE: lag_style_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake: one row at a time
  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !busy;

  // Write pointer and series length
  assign wp_d      = (wp_q == LAST_SLOT) ? '0 : wp_q + AW'(1);
  assign seen_base = series_start_i ? '0 : seen_q;
  assign seen_d    = (seen_base < DEPTH_S) ? seen_base + SEEN_W'(1) : seen_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      cur_q  <= '0;
      seen_q <= '0;
    end else if (in_take) begin
      wp_q   <= wp_d;
      cur_q  <= wp_q;
      seen_q <= seen_d;
    end
  end

  // Column sequencer
  tde_col_gen #(
    .MAX_DIM       (MAX_DIM),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_col_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .embed_dim_i (embed_dim_q),
    .lag_step_i  (lag_step_q),
    .lag_style_i (lag_style_q),
    .start_i     (in_take),
    .issue_i     (issue),
    .cur_i       (cur_q),
    .seen_i      (seen_q),
    .busy_o      (busy),
    .req_valid_o (req_valid),
    .req_o       (req),
    .raddr_o     (raddr)
  );

  // History ring buffer
  tde_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (in_take),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Flow control: read only when the read-data stage will be free
  assign out_take  = out_valid_o && !out_stall_i;
  assign pend_move = pend_q && (!out_valid_o || out_take);
  assign issue     = req_valid && (!pend_q || pend_move);

  // Read-data stage: metadata alongside the held RAM output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (issue) begin
      pend_q <= 1'b1;
    end else if (pend_move) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_meta_q <= req;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (pend_move) begin
      out_valid_o <= 1'b1;
    end else if (out_take) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      lagged_value_o <= pend_meta_q.ok ? rdata : '0;
      valid_res_o    <= pend_meta_q.ok;
      column_o       <= pend_meta_q.column;
      last_o         <= pend_meta_q.last;
    end
  end

endmodule
`default_nettype wire
